// ----- sv/sha1bh_pkg.sv -----
// ----------------------------------------------------------------------------
// sha1bh_pkg
// Shared types, constants and round functions of the SHA-1 block hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1bh_pkg;

	typedef logic [31:0] word_t;
	typedef logic [1:0]  grp_t;

	localparam int NumRounds   = 80;
	localparam int BlockWords  = 16;
	localparam int DigestWords = 5;
	localparam int GroupLen    = 20;

	typedef word_t [DigestWords-1:0] hash_t;

	// Message schedule control
	typedef struct packed {
		logic shift;       // advance the schedule line one word
		logic take_input;  // new word comes from the input beat, not expansion
	} sched_ctl_t;

	// Round datapath control
	typedef struct packed {
		logic load;  // load working variables from the chaining state
		logic step;  // run one round
		grp_t grp;   // round group, selects function and constant
	} rnd_ctl_t;

	localparam grp_t GrpCh     = 2'd0;
	localparam grp_t GrpPar1   = 2'd1;
	localparam grp_t GrpMaj    = 2'd2;
	localparam grp_t GrpPar2   = 2'd3;

	// Standard initial chaining values
	function automatic word_t iv_word(logic [2:0] idx);
		word_t r;
		unique case (idx)
			3'd0:    r = 32'h67452301;
			3'd1:    r = 32'hEFCDAB89;
			3'd2:    r = 32'h98BADCFE;
			3'd3:    r = 32'h10325476;
			3'd4:    r = 32'hC3D2E1F0;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Round constant per group
	function automatic word_t round_k(grp_t g);
		word_t r;
		unique case (g)
			GrpCh:   r = 32'h5A827999;
			GrpPar1: r = 32'h6ED9EBA1;
			GrpMaj:  r = 32'h8F1BBCDC;
			GrpPar2: r = 32'hCA62C1D6;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Round function per group: choose, parity, majority, parity
	function automatic word_t round_f(grp_t g, word_t b, word_t c, word_t d);
		word_t r;
		unique case (g)
			GrpCh:   r = (b & c) | (~b & d);
			GrpMaj:  r = (b & c) | (b & d) | (c & d);
			default: r = b ^ c ^ d;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- sv/sha1_block_hasher_core.sv -----
// ----------------------------------------------------------------------------
// sha1_block_hasher_core
// SHA-1 compression over padded 32-bit big-endian words with digest output.
// ----------------------------------------------------------------------------
// Words are taken one per cycle until a block of sixteen is complete. The
// block then runs 80 rounds, one per cycle through a single round adder,
// and then adds the result into the chaining state; word_ready stays low
// throughout, rounds and update alike. If the word that completes a block
// carries end_of_message, the five digest words follow as five beats
// (index 0 first, digest_last on index 4), word_ready stays low until the
// last beat is taken, and the chaining state returns to the standard
// initial values. A mark on any other word is ignored.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_block_hasher_core
	import sha1bh_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        word_valid,
	output      logic        word_ready,
	input  wire logic [31:0] message_word,
	input  wire logic        end_of_message,
	output      logic        digest_valid,
	input  wire logic        digest_ready,
	output      logic [31:0] digest_word,
	output      logic [2:0]  digest_index,
	output      logic        digest_last
);

	localparam logic [1:0] ST_COLLECT = 2'd0;
	localparam logic [1:0] ST_ROUND   = 2'd1;
	localparam logic [1:0] ST_UPDATE  = 2'd2;
	localparam logic [1:0] ST_EMIT    = 2'd3;

	localparam logic [3:0] LastWordIdx  = 4'(BlockWords - 1);
	localparam logic [6:0] LastRound    = 7'(NumRounds - 1);
	localparam logic [6:0] Grp1Start    = 7'(GroupLen);
	localparam logic [6:0] Grp2Start    = 7'(2 * GroupLen);
	localparam logic [6:0] Grp3Start    = 7'(3 * GroupLen);
	localparam logic [2:0] LastDigIdx   = 3'(DigestWords - 1);

	logic [1:0] state_q;
	logic [3:0] word_cnt_q;
	logic [6:0] round_q;
	logic [2:0] emit_idx_q;
	logic       eom_q;
	hash_t      hash_q;

	logic       word_acc;
	logic       blk_done;
	logic       dig_acc;
	grp_t       grp;
	sched_ctl_t sched_ctl;
	rnd_ctl_t   rnd_ctl;
	word_t      w_cur;
	hash_t      vars;

	// Handshakes
	assign word_ready = (state_q == ST_COLLECT);
	assign word_acc   = word_valid && word_ready;
	assign blk_done   = word_acc && (word_cnt_q == LastWordIdx);
	assign dig_acc    = digest_valid && digest_ready;

	// Round group from round counter
	always_comb begin
		priority if (round_q < Grp1Start) grp = GrpCh;
		else if (round_q < Grp2Start)     grp = GrpPar1;
		else if (round_q < Grp3Start)     grp = GrpMaj;
		else                              grp = GrpPar2;
	end

	// Datapath control
	assign sched_ctl.shift      = word_acc || (state_q == ST_ROUND);
	assign sched_ctl.take_input = (state_q == ST_COLLECT);
	assign rnd_ctl.load         = blk_done;
	assign rnd_ctl.step         = (state_q == ST_ROUND);
	assign rnd_ctl.grp          = grp;

	sha1bh_sched u_sched (
		.clk     (clk),
		.ctl     (sched_ctl),
		.word_in (message_word),
		.w_cur   (w_cur)
	);

	sha1bh_round u_round (
		.clk   (clk),
		.ctl   (rnd_ctl),
		.init  (hash_q),
		.w_cur (w_cur),
		.vars  (vars)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_COLLECT;
			word_cnt_q <= '0;
			round_q    <= '0;
			emit_idx_q <= '0;
			eom_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_COLLECT: begin
					if (word_acc) begin
						word_cnt_q <= word_cnt_q + 4'd1;
					end
					if (blk_done) begin
						eom_q   <= end_of_message;
						round_q <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 7'd1;
					if (round_q == LastRound) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					emit_idx_q <= '0;
					state_q    <= eom_q ? ST_EMIT : ST_COLLECT;
				end
				ST_EMIT: begin
					if (dig_acc) begin
						emit_idx_q <= emit_idx_q + 3'd1;
						if (emit_idx_q == LastDigIdx) begin
							state_q <= ST_COLLECT;
						end
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

	// Chaining state: add round result, then shift out digest while IV shifts in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DigestWords; i++) begin
				hash_q[i] <= iv_word(3'(i));
			end
		end else if (state_q == ST_UPDATE) begin
			for (int i = 0; i < DigestWords; i++) begin
				hash_q[i] <= hash_q[i] + vars[i];
			end
		end else if ((state_q == ST_EMIT) && dig_acc) begin
			for (int i = 0; i < DigestWords - 1; i++) begin
				hash_q[i] <= hash_q[i+1];
			end
			hash_q[DigestWords-1] <= iv_word(emit_idx_q);
		end
	end

	// Digest beat
	assign digest_valid = (state_q == ST_EMIT);
	assign digest_word  = hash_q[0];
	assign digest_index = emit_idx_q;
	assign digest_last  = (emit_idx_q == LastDigIdx);

	// Assertions
	a_cnt_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (word_cnt_q == 4'd0))
		else $error("word count not wrapped during compression");

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_ROUND) && (round_q == LastRound)) |=> (state_q == ST_UPDATE))
		else $error("compression did not end after last round");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (round_q <= LastRound))
		else $error("round counter out of range");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_acc && digest_last) |=> (state_q == ST_COLLECT) && (hash_q[0] == iv_word(3'd0)))
		else $error("state not reloaded after final digest beat");

	a_update_emit: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_UPDATE) && eom_q) |=> (digest_valid && (digest_index == 3'd0)))
		else $error("digest not started after final block");

endmodule

`default_nettype wire

// ----- sv/sha1bh_sched.sv -----
// ----------------------------------------------------------------------------
// sha1bh_sched
// Sixteen-word schedule line. Collects the block words as they arrive and,
// during compression, shifts once per round while appending the expanded word.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1bh_sched
	import sha1bh_pkg::*;
(
	input  wire logic       clk,
	input  wire sched_ctl_t ctl,
	input  wire word_t      word_in,
	output      word_t      w_cur
);

	word_t sl_q [BlockWords];
	word_t mix;
	word_t expand;
	word_t nxt;

	// W[t+16] = rotl1(W[t+13] ^ W[t+8] ^ W[t+2] ^ W[t]); slot 0 holds W[t]
	assign mix    = sl_q[13] ^ sl_q[8] ^ sl_q[2] ^ sl_q[0];
	assign expand = {mix[30:0], mix[31]};
	assign nxt    = ctl.take_input ? word_in : expand;

	// Shift line, oldest word at slot 0
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			for (int i = 0; i < BlockWords - 1; i++) begin
				sl_q[i] <= sl_q[i+1];
			end
			sl_q[BlockWords-1] <= nxt;
		end
	end

	assign w_cur = sl_q[0];

endmodule

`default_nettype wire

// ----- sv/sha1bh_round.sv -----
// ----------------------------------------------------------------------------
// sha1bh_round
// Working variables a..e and the single round adder, reused for all 80 rounds.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1bh_round
	import sha1bh_pkg::*;
(
	input  wire logic     clk,
	input  wire rnd_ctl_t ctl,
	input  wire hash_t    init,
	input  wire word_t    w_cur,
	output      hash_t    vars
);

	word_t a_q, b_q, c_q, d_q, e_q;
	word_t tmp;

	// tmp = rotl5(a) + f(b,c,d) + e + K + W
	assign tmp = {a_q[26:0], a_q[31:27]} + round_f(ctl.grp, b_q, c_q, d_q) + e_q
		+ round_k(ctl.grp) + w_cur;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= init[0];
			b_q <= init[1];
			c_q <= init[2];
			d_q <= init[3];
			e_q <= init[4];
		end else if (ctl.step) begin
			a_q <= tmp;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};  // rotl30
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	assign vars[0] = a_q;
	assign vars[1] = b_q;
	assign vars[2] = c_q;
	assign vars[3] = d_q;
	assign vars[4] = e_q;

endmodule

`default_nettype wire
